// File: sv/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants of the RGB/CMYK converter
// Pixel structs for both channels and the full-scale channel value.
// ----------------------------------------------------------------------------
package rcc_pkg;

	localparam logic [7:0] FULL_SCALE = 8'd255;

	localparam logic DIR_RGB_TO_CMYK = 1'b0;
	localparam logic DIR_CMYK_TO_RGB = 1'b1;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] cyan_in;
		logic [7:0] magenta_in;
		logic [7:0] yellow_in;
		logic [7:0] black_in;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] cyan_out;
		logic [7:0] magenta_out;
		logic [7:0] yellow_out;
		logic [7:0] black_out;
	} pixel_out_t;

endpackage

// File: sv/rgb_cmyk_converter.sv
// ----------------------------------------------------------------------------
// rgb_cmyk_converter: pipelined 8-bit RGB <-> CMYK pixel converter
// Seven-stage pipeline around a shared restoring divider, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the input channel (in_valid, in_stall, in_pixel) and results
// leave on the output channel (out_valid, out_stall, out_pixel). A transaction
// completes on a rising edge of clk where valid is high and stall is low.
// The direction register is written through cfg_wr_en / cfg_wr_data while
// the pipeline is empty: 0 converts RGB to CMYK, 1 converts CMYK to RGB.
// A pixel accepted into stage 1 passes stages 2 to 6 and is presented from
// the stage 7 register. Throughput is one pixel per clock while the receiver
// does not stall; every stage holds one pixel and the divider takes two
// quotient bits per stage over four stages, so that chain of compares sets the pipeline depth.
// When the receiver stalls, the output stage holds its result and stages
// behind it keep filling until they meet a full stage; only then is in_stall
// raised. Empty stages are squeezed out, so no transaction is lost or repeated.
// Reset (arst_n low) empties the pipeline and sets the direction to RGB to CMYK.
// ----------------------------------------------------------------------------
module rgb_cmyk_converter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic                   cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  rcc_pkg::pixel_in_t     in_pixel,
	output logic                   out_valid,
	input  logic                   out_stall,
	output rcc_pkg::pixel_out_t    out_pixel
);
	import rcc_pkg::*;

	// Remainder and quotient of one channel inside the divider.
	typedef struct packed {
		logic [15:0] rem;
		logic [7:0]  quo;
	} div_t;

	// Two restoring division steps, for quotient bits hi and hi-1. The
	// numerator is below 256 times the divisor unless the divisor is zero, so
	// eight bits of quotient suffice and the shifted divisor fits in sixteen bits.
	function automatic div_t div_step2(div_t cur, logic [7:0] d, logic [2:0] hi);
		div_t        nxt;
		logic [15:0] sub;
		logic [2:0]  pos;
		nxt = cur;
		for (int j = 0; j < 2; j++) begin
			pos = hi - 3'(j);
			sub = {8'd0, d} << pos;
			if (nxt.rem >= sub) begin
				nxt.rem = nxt.rem - sub;
				nxt.quo[pos] = 1'b1;
			end
		end
		return nxt;
	endfunction

	// Configuration.
	logic dir_q;

	// Valid bits and stage ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	// Stage 1: color values with black separated out.
	logic             dir_s1;
	logic [2:0][7:0]  x_s1;
	logic [7:0]       k_s1;

	// Stage 2: numerators and divisor.
	logic             dir_s2, zero_s2;
	logic [7:0]       k_s2, d_s2;
	logic [2:0][15:0] n_s2;

	// Stages 3 to 6: divider.
	logic             dir_s3, dir_s4, dir_s5, dir_s6;
	logic             zero_s3, zero_s4, zero_s5, zero_s6;
	logic [7:0]       k_s3, k_s4, k_s5, k_s6;
	logic [7:0]       d_s3, d_s4, d_s5;
	div_t [2:0]       div_s3, div_s4, div_s5, div_s6;

	// Stage 7: output register.
	pixel_out_t       pix_s7;

	// Stage 1 input logic.
	logic [2:0][7:0]  x_in;
	logic [7:0]       k_in, min_cm;

	// Stage 2 input logic.
	logic [2:0][15:0] n_in;
	logic [2:0][7:0]  diff_in;

	// Output formatting.
	pixel_out_t       pix_in;
	logic [2:0][7:0]  sum_in;

	// A stage may load when it is empty or when the stage after it moves.
	assign rdy7 = ~v_s7 | ~out_stall;
	assign rdy6 = ~v_s6 | rdy7;
	assign rdy5 = ~v_s5 | rdy6;
	assign rdy4 = ~v_s4 | rdy5;
	assign rdy3 = ~v_s3 | rdy4;
	assign rdy2 = ~v_s2 | rdy3;
	assign rdy1 = ~v_s1 | rdy2;
	assign in_stall  = ~rdy1;
	assign out_valid = v_s7;
	assign out_pixel = pix_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_RGB_TO_CMYK;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dir_q <= cfg_wr_data;
			end
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	// In RGB to CMYK mode the colors are inverted and black is their minimum.
	always_comb begin
		if (dir_q == DIR_RGB_TO_CMYK) begin
			x_in[0] = FULL_SCALE - in_pixel.red_in;
			x_in[1] = FULL_SCALE - in_pixel.green_in;
			x_in[2] = FULL_SCALE - in_pixel.blue_in;
			min_cm  = (x_in[0] < x_in[1]) ? x_in[0] : x_in[1];
			k_in    = (min_cm < x_in[2]) ? min_cm : x_in[2];
		end else begin
			x_in[0] = in_pixel.cyan_in;
			x_in[1] = in_pixel.magenta_in;
			x_in[2] = in_pixel.yellow_in;
			min_cm  = in_pixel.black_in;
			k_in    = in_pixel.black_in;
		end
	end

	// Both directions are one division: (x - k) * 255 / (255 - k) going to
	// CMYK, and x * (255 - k) / 255 going to RGB.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff_in[i] = x_s1[i] - k_s1;
			if (dir_s1 == DIR_RGB_TO_CMYK) begin
				n_in[i] = {diff_in[i], 8'd0} - {8'd0, diff_in[i]};
			end else begin
				n_in[i] = {8'd0, x_s1[i]} * {8'd0, FULL_SCALE - k_s1};
			end
		end
	end

	// Full black forces the colors to zero going to CMYK and the RGB values
	// to zero going the other way.
	always_comb begin
		pix_in = '0;
		for (int i = 0; i < 3; i++) begin
			sum_in[i] = div_s6[i].quo + k_s6;
		end
		if (dir_s6 == DIR_RGB_TO_CMYK) begin
			pix_in.black_out = k_s6;
			if (!zero_s6) begin
				pix_in.cyan_out    = div_s6[0].quo;
				pix_in.magenta_out = div_s6[1].quo;
				pix_in.yellow_out  = div_s6[2].quo;
			end
		end else if (!zero_s6) begin
			pix_in.red_out   = FULL_SCALE - sum_in[0];
			pix_in.green_out = FULL_SCALE - sum_in[1];
			pix_in.blue_out  = FULL_SCALE - sum_in[2];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			dir_s1 <= dir_q;
			x_s1   <= x_in;
			k_s1   <= k_in;
		end
		if (rdy2) begin
			dir_s2  <= dir_s1;
			k_s2    <= k_s1;
			zero_s2 <= (k_s1 == FULL_SCALE);
			d_s2    <= (dir_s1 == DIR_RGB_TO_CMYK) ? (FULL_SCALE - k_s1) : FULL_SCALE;
			n_s2    <= n_in;
		end
		if (rdy3) begin
			dir_s3  <= dir_s2;
			zero_s3 <= zero_s2;
			k_s3    <= k_s2;
			d_s3    <= d_s2;
			for (int i = 0; i < 3; i++) begin
				div_s3[i] <= div_step2('{rem: n_s2[i], quo: 8'd0}, d_s2, 3'd7);
			end
		end
		if (rdy4) begin
			dir_s4  <= dir_s3;
			zero_s4 <= zero_s3;
			k_s4    <= k_s3;
			d_s4    <= d_s3;
			for (int i = 0; i < 3; i++) begin
				div_s4[i] <= div_step2(div_s3[i], d_s3, 3'd5);
			end
		end
		if (rdy5) begin
			dir_s5  <= dir_s4;
			zero_s5 <= zero_s4;
			k_s5    <= k_s4;
			d_s5    <= d_s4;
			for (int i = 0; i < 3; i++) begin
				div_s5[i] <= div_step2(div_s4[i], d_s4, 3'd3);
			end
		end
		if (rdy6) begin
			dir_s6  <= dir_s5;
			zero_s6 <= zero_s5;
			k_s6    <= k_s5;
			for (int i = 0; i < 3; i++) begin
				div_s6[i] <= div_step2(div_s5[i], d_s5, 3'd1);
			end
		end
		if (rdy7) begin
			pix_s7 <= pix_in;
		end
	end

endmodule

// File: tb/rgb_cmyk_converter_checker.sv
// ----------------------------------------------------------------------------
// rgb_cmyk_converter_checker: result predictor and scoreboard
// Watches the configuration port and both pixel channels of the converter.
// For every accepted input pixel it computes the expected result under the
// current direction. Each accepted output pixel is compared with the oldest
// expected pixel, one field at a time.
// ----------------------------------------------------------------------------
module rgb_cmyk_converter_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  rcc_pkg::pixel_in_t  in_pixel,
	input  logic                out_valid,
	input  logic                out_stall,
	input  rcc_pkg::pixel_out_t out_pixel,
	output int unsigned         outstanding,
	output int unsigned         mismatches
);
	import rcc_pkg::*;

	localparam int unsigned FULL = 32'(FULL_SCALE);

	string field_name [7] = '{"red_out", "green_out", "blue_out", "cyan_out",
		"magenta_out", "yellow_out", "black_out"};

	pixel_out_t  expected_pixels [$];
	logic        conv_dir = DIR_RGB_TO_CMYK;
	int unsigned fail_count = 0;

	// Removes the black share from one ink; k is below full scale and at most x.
	function automatic logic [7:0] remove_key(input int unsigned x, input int unsigned k);
		return 8'(((x - k) * FULL) / (FULL - k));
	endfunction

	// Folds the black share back into one ink; k is below full scale.
	function automatic int unsigned merge_key(input int unsigned x, input int unsigned k);
		return (x * (FULL - k)) / FULL + k;
	endfunction

	function automatic pixel_out_t convert_pixel(input pixel_in_t px, input logic dir);
		pixel_out_t  res;
		int unsigned c, m, y, k;
		res = '0;
		if (dir == DIR_RGB_TO_CMYK) begin
			c = FULL - 32'(px.red_in);
			m = FULL - 32'(px.green_in);
			y = FULL - 32'(px.blue_in);
			k = c;
			if (m < k) k = m;
			if (y < k) k = y;
			if (k != FULL) begin
				res.cyan_out    = remove_key(c, k);
				res.magenta_out = remove_key(m, k);
				res.yellow_out  = remove_key(y, k);
			end
			res.black_out = 8'(k);
		end else begin
			k = 32'(px.black_in);
			c = FULL;
			m = FULL;
			y = FULL;
			if (k != FULL) begin
				c = merge_key(32'(px.cyan_in), k);
				m = merge_key(32'(px.magenta_in), k);
				y = merge_key(32'(px.yellow_in), k);
			end
			res.red_out   = 8'(FULL - c);
			res.green_out = 8'(FULL - m);
			res.blue_out  = 8'(FULL - y);
		end
		return res;
	endfunction

	always @(posedge clk) begin : scoreboard
		pixel_out_t want;
		logic [7:0] want_b, got_b;
		bit         bad;
		if (!arst_n) begin
			conv_dir = DIR_RGB_TO_CMYK;
			expected_pixels.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					if (fail_count < 10)
						$display("[%0t] output transaction %h with nothing pending",
							$realtime, out_pixel);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					bad = 1'b0;
					for (int i = 0; i < 7; i++) begin
						want_b = want[55 - 8 * i -: 8];
						got_b  = out_pixel[55 - 8 * i -: 8];
						if (got_b !== want_b) begin
							if (fail_count < 10)
								$display("[%0t] %s mismatch: expected %0d, got %0d",
									$realtime, field_name[i], want_b, got_b);
							bad = 1'b1;
						end
					end
					if (bad) fail_count++;
				end
			end
			if (in_valid && !in_stall)
				expected_pixels.push_back(convert_pixel(in_pixel, conv_dir));
			if (cfg_wr_en)
				conv_dir = cfg_wr_data;
		end
		outstanding <= expected_pixels.size();
		mismatches  <= fail_count;
	end

endmodule

// File: tb/rgb_cmyk_converter_tb.sv
// ----------------------------------------------------------------------------
// rgb_cmyk_converter_tb: self-checking testbench of the RGB/CMYK converter
// Drives directed corner pixels and then randomized pixel streams in both
// conversion directions, with bursty input traffic and a shifting output
// stall pattern, while a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module rgb_cmyk_converter_tb;
	import rcc_pkg::*;

	// Pipeline latency from an accepted pixel to its result; it sizes the final wait.
	localparam int LATENCY = 6;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int RANDOM_PHASES = 6;

	typedef enum {LEVEL_UNIFORM, LEVEL_GRAY, LEVEL_CORNER} level_style_t;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid = 1'b0;
	pixel_in_t   in_pixel = '0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	pixel_out_t  out_pixel;
	int unsigned outstanding;
	int unsigned mismatches;

	// Pixels left in the current input burst; zero means a gap may come next.
	int unsigned burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	rgb_cmyk_converter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_pixel   (in_pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pixel  (out_pixel)
	);

	rgb_cmyk_converter_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_pixel   (in_pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pixel  (out_pixel),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	// The receiver switches to a randomly chosen stall mode whenever the current
	// one runs out. The modes range from never stalling, through light and heavy
	// random stalls, to a fixed periodic duty cycle, so backpressure meets the
	// pipeline at every fill level.
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned mode_left = 0;
	int unsigned stall_tick = 0;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 96);
		end
		mode_left--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_tick % 8) < 5);
		endcase
	end

	// One channel level in the chosen style. Gray levels cluster around a
	// shared base so that the three inks come out close to each other, which
	// makes the black share large and the remaining ink small.
	function automatic logic [7:0] pick_level(input level_style_t style, input int base);
		int v;
		case (style)
			LEVEL_GRAY: begin
				v = base + int'($urandom_range(0, 8)) - 4;
				if (v < 0) v = 0;
				if (v > 255) v = 255;
				return 8'(v);
			end
			LEVEL_CORNER: begin
				case ($urandom_range(0, 3))
					0: return 8'd0;
					1: return 8'd1;
					2: return 8'd254;
					default: return 8'd255;
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// A random pixel for the given direction. The fields that the direction
	// ignores still carry random values, so the converter must really ignore
	// them.
	function automatic pixel_in_t random_pixel(input logic dir);
		pixel_in_t    p;
		level_style_t style;
		int           base;
		p.red_in     = 8'($urandom_range(0, 255));
		p.green_in   = 8'($urandom_range(0, 255));
		p.blue_in    = 8'($urandom_range(0, 255));
		p.cyan_in    = 8'($urandom_range(0, 255));
		p.magenta_in = 8'($urandom_range(0, 255));
		p.yellow_in  = 8'($urandom_range(0, 255));
		p.black_in   = 8'($urandom_range(0, 255));
		style = level_style_t'($urandom_range(0, 2));
		base = $urandom_range(0, 255);
		if (dir == DIR_RGB_TO_CMYK) begin
			p.red_in   = pick_level(style, base);
			p.green_in = pick_level(style, base);
			p.blue_in  = pick_level(style, base);
		end else begin
			p.cyan_in    = pick_level(style, base);
			p.magenta_in = pick_level(style, base);
			p.yellow_in  = pick_level(style, base);
			// Full black, black one step short of full and no black are weighted
			// up; full black is where the conversion takes its special path.
			case ($urandom_range(0, 7))
				0: p.black_in = FULL_SCALE;
				1: p.black_in = 8'd0;
				2: p.black_in = 8'd254;
				default: ;
			endcase
		end
		return p;
	endfunction

	// Offers one pixel and returns at the edge where the transaction completes.
	// Between bursts of back-to-back pixels the sender sometimes rests with
	// valid low; a valid that stays high is never lowered in between.
	task automatic send_pixel(input pixel_in_t p);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_pixel <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		pixel_in_t p;
		p = random_pixel(DIR_RGB_TO_CMYK);
		p.red_in = r;
		p.green_in = g;
		p.blue_in = b;
		send_pixel(p);
	endtask

	task automatic send_cmyk(input logic [7:0] c, input logic [7:0] m, input logic [7:0] y,
			input logic [7:0] k);
		pixel_in_t p;
		p = random_pixel(DIR_CMYK_TO_RGB);
		p.cyan_in = c;
		p.magenta_in = m;
		p.yellow_in = y;
		p.black_in = k;
		send_pixel(p);
	endtask

	// Stops offering pixels and waits until every expected result has been
	// taken. Every pixel yields exactly one result, so the pipeline is empty
	// once nothing is outstanding.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// The direction register may only change while the pipeline is empty.
	task automatic set_direction(input logic dir);
		drain_pipeline();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= dir;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		logic dir;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed RGB to CMYK pixels: an all-black pixel, white, the
		// primaries, yellow, and near-black pixels where the divisor
		// of the black removal is at its smallest.
		set_direction(DIR_RGB_TO_CMYK);
		send_rgb(8'd0, 8'd0, 8'd0);
		send_rgb(8'd255, 8'd255, 8'd255);
		send_rgb(8'd255, 8'd0, 8'd0);
		send_rgb(8'd0, 8'd255, 8'd0);
		send_rgb(8'd0, 8'd0, 8'd255);
		send_rgb(8'd255, 8'd255, 8'd0);
		send_rgb(8'd1, 8'd1, 8'd1);
		send_rgb(8'd1, 8'd0, 8'd0);
		send_rgb(8'd254, 8'd255, 8'd255);
		send_rgb(8'd128, 8'd64, 8'd32);

		// Directed CMYK to RGB pixels: no ink, full ink without black (plain
		// CMY), full black with and without other ink, and black one step
		// short of full.
		set_direction(DIR_CMYK_TO_RGB);
		send_cmyk(8'd0, 8'd0, 8'd0, 8'd0);
		send_cmyk(8'd255, 8'd255, 8'd255, 8'd0);
		send_cmyk(8'd0, 8'd0, 8'd0, 8'd255);
		send_cmyk(8'd255, 8'd128, 8'd7, 8'd255);
		send_cmyk(8'd255, 8'd255, 8'd255, 8'd254);
		send_cmyk(8'd0, 8'd0, 8'd0, 8'd254);
		send_cmyk(8'd200, 8'd100, 8'd50, 8'd0);
		send_cmyk(8'd1, 8'd254, 8'd128, 8'd1);
		send_cmyk(8'd128, 8'd128, 8'd128, 8'd128);

		// Random phases: the first two cover both directions in turn, the
		// rest pick a direction at random.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase < 2)
				dir = (phase == 0) ? DIR_RGB_TO_CMYK : DIR_CMYK_TO_RGB;
			else
				dir = ($urandom_range(0, 1) == 0) ? DIR_RGB_TO_CMYK : DIR_CMYK_TO_RGB;
			set_direction(dir);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_pixel(random_pixel(dir));
		end

		// Let every result come out, then watch a little longer for any
		// spurious output transaction.
		drain_pipeline();
		repeat (LATENCY * 4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("rgb_cmyk_converter_tb OK");
		else
			$display("rgb_cmyk_converter_tb NOT OK");
		$finish;
	end

	// Guard against a hung handshake; a correct run needs far less time.
	initial begin
		#2000000;
		$display("rgb_cmyk_converter_tb NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
sv/rcc_pkg.sv
sv/rgb_cmyk_converter.sv
tb/rgb_cmyk_converter_checker.sv
tb/rgb_cmyk_converter_tb.sv
